[hdl/jfo_pkg.sv]
// Package for the joint friction observer: payload types, codes, sizes.
// No dependencies.
`default_nettype none
package jfo_pkg;
  localparam int JOINT_COUNT = 8;
  localparam int JW = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
  // Number of arithmetic steps before the gain and filter phase (PID path).
  localparam int NSTEP = 16;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0, CMD_INIT = 2'd1, CMD_EST = 2'd2, CMD_NOP = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_DT = 2'd0, REG_FW = 2'd1, REG_OBS = 2'd2, REG_INT = 2'd3
  } reg_e;

  // Sequencer states of the top level.
  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_OUT} st_e;

  // ALU operations of the shared unit.
  typedef enum logic [2:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_NEG, OP_HALF, OP_MIX
  } op_e;

  typedef struct packed {
    logic [1:0]         command;
    logic [2:0]         joint;
    logic signed [31:0] sensed_position;
    logic signed [31:0] sensed_velocity;
    logic signed [31:0] torque_commanded;
    logic signed [31:0] torque_measured;
    logic signed [31:0] inertia_value;
    logic signed [31:0] gain_l_value;
    logic signed [31:0] gain_p_value;
    logic signed [31:0] gain_i_value;
  } in_t;

  typedef struct packed {
    logic [2:0]         result_joint;
    logic signed [31:0] friction;
    logic signed [31:0] nominal_position;
    logic signed [31:0] nominal_velocity;
    logic               saturated;
  } out_t;

  typedef struct packed {
    op_e                op;
    logic signed [33:0] a;
    logic signed [33:0] b;
    logic signed [33:0] c;
  } alu_req_t;

  typedef struct packed {
    logic signed [31:0] y;
    logic               clip;
  } alu_rsp_t;
endpackage
`default_nettype wire

[hdl/jfo_alu.sv]
// Shared saturating arithmetic unit: add, subtract, Q16 multiply, negate,
// halve, filter mix. Depends on jfo_pkg.
`default_nettype none
module jfo_alu import jfo_pkg::*; (
  input  wire alu_req_t req_i,
  output alu_rsp_t      rsp_o
);
  logic signed [67:0] wide;
  logic signed [67:0] sh;
  logic signed [34:0] mb;
  logic signed [67:0] prod;

  // One multiplier serves both the Q16 product and the filter mix. The mix
  // w*prev + (1-w)*est is formed as est + w*(prev - est), which floors the
  // same way because est*65536 is a multiple of 65536.
  always_comb begin
    mb   = (req_i.op == OP_MIX) ? (35'(req_i.b) - 35'(req_i.c)) : 35'(req_i.b);
    prod = 68'(req_i.a) * 68'(mb);
  end

  // Operands are sign extended; multiply results are floored by 16 bits.
  always_comb begin
    wide = '0;
    unique case (req_i.op)
      OP_ADD:  wide = 68'(req_i.a) + 68'(req_i.b);
      OP_SUB:  wide = 68'(req_i.a) - 68'(req_i.b);
      OP_MUL:  wide = prod >>> 16;
      OP_NEG:  wide = -68'(req_i.a);
      OP_HALF: wide = 68'(req_i.a) >>> 1;
      OP_MIX:  wide = (prod >>> 16) + 68'(req_i.c);
      default: wide = '0;
    endcase
    sh = wide;
    if (sh > 68'sd2147483647) begin
      rsp_o.y = 32'sh7fffffff; rsp_o.clip = 1'b1;
    end else if (sh < -68'sd2147483648) begin
      rsp_o.y = 32'sh80000000; rsp_o.clip = 1'b1;
    end else begin
      rsp_o.y = sh[31:0]; rsp_o.clip = 1'b0;
    end
  end
endmodule
`default_nettype wire

[hdl/joint_friction_observer.sv]
// Joint friction observer top level: per-joint stores, step sequencer and
// one shared arithmetic unit. Depends on jfo_pkg and jfo_alu.
//
// Usage: input beats (in_valid_i/in_stall_o) carry a command and a joint.
// Each beat yields exactly one result beat (out_valid_o/out_stall_i).
// Load, init and no-op items pass through the run state once, and their
// result beat is then presented. An estimate walks the sequencer through
// 12 steps of the shared arithmetic unit (16 with the PID integral) and
// then 4 gain and filter steps, one step a cycle, before its result is
// presented. The sequencer handles one item at a time; the input stalls
// from acceptance until the result is taken and the next beat is taken no
// sooner than the cycle after that.
// A stalled result holds in place, unchanged, until taken.
// Configuration writes (cfg_valid_i/cfg_ready_o) are always taken and go
// to time_step, filter_weight, observer_kind and integrator_kind; they
// belong between items, while nothing is in flight.
// Reset clears the state stores and all control state and presets the
// config; working registers and gain stores are undefined until loaded.
`default_nettype none
module joint_friction_observer import jfo_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_stall_o,
  input  wire in_t   in_data_i,
  output logic       out_valid_o,
  input  wire        out_stall_i,
  output out_t       out_data_o,
  input  wire        cfg_valid_i,
  output logic       cfg_ready_o,
  input  wire [1:0]  cfg_index_i,
  input  wire [31:0] cfg_data_i
);
  st_e st_q, st_d;
  logic [3:0] step_q, step_d;
  logic [1:0] ph_q, ph_d;
  logic tail_q, tail_d;
  in_t item_q;
  logic sat_q, sat_d;
  logic signed [31:0] pos_q, vel_q, acc_q, dv_q, t0_q, e_q, inner_q, g_q, sum_q, est_q;
  logic [16:0] dt_q, fw_q;
  logic obs_q, int_q;

  logic signed [31:0] pos_s [JOINT_COUNT];
  logic signed [31:0] vel_s [JOINT_COUNT];
  logic signed [31:0] sum_s [JOINT_COUNT];
  logic signed [31:0] flt_s [JOINT_COUNT];
  logic signed [31:0] ine_s [JOINT_COUNT];
  logic signed [31:0] gl_s  [JOINT_COUNT];
  logic signed [31:0] gp_s  [JOINT_COUNT];
  logic signed [31:0] gi_s  [JOINT_COUNT];

  alu_req_t req, req2, rq;
  alu_rsp_t rsp;

  logic [JW-1:0] j;
  logic jok;
  logic signed [33:0] dtx, fwx;

  // The single unit sees whichever request the sequencer phase selects.
  assign rq = tail_q ? req2 : req;
  jfo_alu u_alu (.req_i(rq), .rsp_o(rsp));

  assign j   = item_q.joint[JW-1:0];
  assign jok = 32'(item_q.joint) < JOINT_COUNT;
  assign dtx = 34'(signed'({1'b0, dt_q}));
  assign fwx = (fw_q > 17'd65536) ? 34'sd65536 : 34'(signed'({1'b0, fw_q}));

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (st_q != ST_IDLE);
  assign out_valid_o = (st_q == ST_OUT);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q <= 17'd65; fw_q <= '0; obs_q <= 1'b0; int_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (reg_e'(cfg_index_i))
        REG_DT:  dt_q  <= cfg_data_i[16:0];
        REG_FW:  fw_q  <= cfg_data_i[16:0];
        REG_OBS: obs_q <= cfg_data_i[0];
        REG_INT: int_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Operand selection per estimate step.
  always_comb begin
    req = '{op: OP_ADD, a: '0, b: '0, c: '0};
    unique case (step_q)
      4'd0:  req = '{OP_SUB, 34'(item_q.torque_commanded), 34'(item_q.torque_measured), '0};
      4'd1:  req = '{OP_MUL, 34'(t0_q), 34'(ine_s[j]), '0};
      4'd2:  req = '{OP_MUL, 34'(acc_q), dtx, '0};
      4'd3: begin
        if (int_q) req = '{OP_HALF, 34'(dv_q), '0, '0};
        else req = '{OP_ADD, 34'(vel_q), 34'(dv_q), '0};
      end
      4'd4: begin
        if (int_q) req = '{OP_ADD, 34'(vel_q), 34'(t0_q), '0};
        else req = '{OP_MUL, 34'(vel_q), dtx, '0};
      end
      4'd5: begin
        if (int_q) req = '{OP_MUL, 34'(t0_q), dtx, '0};
        else req = '{OP_ADD, 34'(pos_q), 34'(t0_q), '0};
      end
      4'd6: begin
        if (int_q) req = '{OP_ADD, 34'(pos_q), 34'(t0_q), '0};
        else req = '{OP_ADD, 34'(pos_q), '0, '0};
      end
      4'd7: begin
        if (int_q) req = '{OP_ADD, 34'(vel_q), 34'(dv_q), '0};
        else req = '{OP_ADD, 34'(vel_q), '0, '0};
      end
      4'd8:  req = '{OP_SUB, 34'(pos_q), 34'(item_q.sensed_position), '0};
      4'd9:  req = '{OP_SUB, 34'(vel_q), 34'(item_q.sensed_velocity), '0};
      4'd10: req = '{OP_MUL, 34'(gp_s[j]), 34'(e_q), '0};
      4'd11: req = '{OP_ADD, 34'(inner_q), 34'(t0_q), '0};
      4'd12: req = '{OP_MUL, 34'(e_q), dtx, '0};
      4'd13: req = '{OP_ADD, 34'(sum_s[j]), 34'(t0_q), '0};
      4'd14: req = '{OP_MUL, 34'(gi_s[j]), 34'(sum_q), '0};
      4'd15: req = '{OP_ADD, 34'(inner_q), 34'(t0_q), '0};
      default: ;
    endcase
  end

  // Second phase: gain product, negate, estimate and filter mix reuse
  // the same unit; step_q holds while ph_q walks the four phases.
  always_comb begin
    unique case (ph_q)
      2'd0: req2 = '{OP_MUL, 34'(ine_s[j]), 34'(gl_s[j]), '0};
      2'd1: req2 = '{OP_NEG, 34'(g_q), '0, '0};
      2'd2: req2 = '{OP_MUL, 34'(g_q), 34'(inner_q), '0};
      default: req2 = '{OP_MIX, fwx, 34'(flt_s[j]), 34'(est_q)};
    endcase
  end

  // Sequencer.
  always_comb begin
    st_d = st_q; step_d = step_q; ph_d = ph_q; tail_d = tail_q; sat_d = sat_q;
    unique case (st_q)
      ST_IDLE: if (in_valid_i) begin
        st_d = ST_RUN; step_d = '0; ph_d = '0; tail_d = 1'b0; sat_d = 1'b0;
      end
      ST_RUN: begin
        if (!jok || item_q.command != CMD_EST) st_d = ST_OUT;
        else begin
          sat_d = sat_q | rsp.clip;
          if (!tail_q) begin
            if (step_q == 4'd11 && !obs_q) tail_d = 1'b1;
            else if (step_q == 4'(NSTEP - 1)) tail_d = 1'b1;
            else step_d = step_q + 4'd1;
          end else if (ph_q == 2'd3) st_d = ST_OUT;
          else ph_d = ph_q + 2'd1;
        end
      end
      ST_OUT: if (!out_stall_i) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; step_q <= '0; ph_q <= '0; tail_q <= 1'b0; sat_q <= 1'b0;
    end else begin
      st_q <= st_d; step_q <= step_d; ph_q <= ph_d; tail_q <= tail_d; sat_q <= sat_d;
    end
  end

  // Per-joint state stores, cleared at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < JOINT_COUNT; k++) begin
        pos_s[k] <= '0; vel_s[k] <= '0; sum_s[k] <= '0; flt_s[k] <= '0;
      end
    end else if (st_q == ST_RUN && jok) begin
      unique case (cmd_e'(item_q.command))
        CMD_INIT: begin
          pos_s[j] <= item_q.sensed_position; vel_s[j] <= item_q.sensed_velocity;
          sum_s[j] <= '0; flt_s[j] <= '0;
        end
        CMD_EST: if (!tail_q) begin
          if (step_q == 4'd7) begin pos_s[j] <= pos_q; vel_s[j] <= rsp.y; end
          if (step_q == 4'd13) sum_s[j] <= rsp.y;
        end else if (ph_q == 2'd3) flt_s[j] <= rsp.y;
        default: ;
      endcase
    end
  end

  // Per-joint gain stores have no reset; a load command fills them.
  always_ff @(posedge clk_i) begin
    if (st_q == ST_RUN && jok && item_q.command == CMD_LOAD) begin
      ine_s[j] <= item_q.inertia_value; gl_s[j] <= item_q.gain_l_value;
      gp_s[j] <= item_q.gain_p_value; gi_s[j] <= item_q.gain_i_value;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == ST_IDLE && in_valid_i) begin
      item_q <= in_data_i;
      pos_q <= pos_s[in_data_i.joint[JW-1:0]];
      vel_q <= vel_s[in_data_i.joint[JW-1:0]];
    end else if (st_q == ST_RUN && !tail_q) begin
      unique case (step_q)
        4'd0: t0_q <= rsp.y;
        4'd1: acc_q <= rsp.y;
        4'd2: dv_q <= rsp.y;
        4'd3: if (int_q) t0_q <= rsp.y; else vel_q <= rsp.y;
        4'd4: t0_q <= rsp.y;
        4'd5: if (int_q) t0_q <= rsp.y; else pos_q <= rsp.y;
        4'd6: pos_q <= rsp.y;
        4'd7: vel_q <= rsp.y;
        4'd8: e_q <= rsp.y;
        4'd9: inner_q <= rsp.y;
        4'd10: t0_q <= rsp.y;
        4'd11: inner_q <= rsp.y;
        4'd12: t0_q <= rsp.y;
        4'd13: sum_q <= rsp.y;
        4'd14: t0_q <= rsp.y;
        default: inner_q <= rsp.y;
      endcase
    end else if (st_q == ST_RUN) begin
      unique case (ph_q)
        2'd0, 2'd1: g_q <= rsp.y;
        2'd2: est_q <= rsp.y;
        default: ;
      endcase
    end
  end

  // Result contents come combinationally from the stores after the step.
  always_comb begin
    out_data_o = '0;
    out_data_o.result_joint = item_q.joint;
    if (jok) begin
      out_data_o.friction = flt_s[j];
      out_data_o.nominal_position = pos_s[j];
      out_data_o.nominal_velocity = vel_s[j];
      out_data_o.saturated = (item_q.command == CMD_EST) & sat_q;
    end
  end

`ifndef SYNTH
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != ST_IDLE) |-> in_stall_o) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o) else $error("result dropped");
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(out_data_o)) else $error("result changed");
  a_run_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_OUT) |-> !tail_d || tail_q) else $error("bad tail");
`endif
endmodule
`default_nettype wire
